// ----- rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the closest-hit search block.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rchs_pkg.sv -----
// -----------------------------------------------------------------------------
// rchs_pkg
// Types, widths and codes shared by the closest-hit search block.
// -----------------------------------------------------------------------------
package rchs_pkg;

  // table sizes
  localparam int SPHERE_SLOTS = 16;
  localparam int PLANE_SLOTS  = 16;
  localparam int SPH_AW = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;
  localparam int PLN_AW = (PLANE_SLOTS > 1) ? $clog2(PLANE_SLOTS) : 1;

  // field widths
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int COORD_W    = 32;
  localparam int RAD_W      = 31;
  localparam int COLOR_W    = 24;
  localparam int DIST_W     = 31;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // arithmetic widths
  localparam int MW     = 70;          // signed multiplier operand
  localparam int PW     = 2 * MW;      // signed product / accumulator
  localparam int SQ_W   = 136;         // root radicand
  localparam int RT_W   = SQ_W / 2;    // root result
  localparam int FRAC_W = 16;
  localparam int NW     = MW + FRAC_W; // dividend
  localparam int DW     = MW;          // divisor

  localparam logic [MW-1:0]     EPS_DOT  = MW'(429496);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // request modes
  localparam logic [MODE_W-1:0] MODE_SPH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CAST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 2'd2;

  typedef logic signed [MW-1:0] op_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic [RAD_W-1:0]          radius;
    logic [COLOR_W-1:0]        color;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               kind;
    logic [SLOT_W-1:0]  object_slot;
    logic [DIST_W-1:0]  distance;
    logic [COLOR_W-1:0] pixel_color;
  } res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          radius;
    logic [COLOR_W-1:0]        color;
  } sphere_ent_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic [COLOR_W-1:0]        color;
  } plane_ent_t;

endpackage

// ----- rtl/rchs_ram.sv -----
// -----------------------------------------------------------------------------
// rchs_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module rchs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rchs_mul.sv -----
// -----------------------------------------------------------------------------
// rchs_mul
// Shift-add signed multiplier, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module rchs_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  rchs_pkg::op_t  x,
  input  rchs_pkg::op_t  y,
  output logic           done,
  output rchs_pkg::prod_t p
);
  import rchs_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] ma;
  logic [MW-1:0] hi;
  logic [MW-1:0] lo;
  logic [MW:0]   sum;
  logic [CW-1:0] cnt;
  logic          run;
  logic          sgn;
  logic [PW-1:0] mag;

  // add multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, ma} : '0);
  assign mag = {hi, lo};
  assign p   = sgn ? -prod_t'(mag) : prod_t'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        ma  <= x[MW-1] ? MW'(-x) : MW'(x);
        lo  <= y[MW-1] ? MW'(-y) : MW'(y);
        hi  <= '0;
        sgn <= x[MW-1] ^ y[MW-1];
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        // shift the partial product right by one
        hi  <= sum[MW:1];
        lo  <= {sum[0], lo[MW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/rchs_root.sv -----
// -----------------------------------------------------------------------------
// rchs_root
// Restoring integer square root, one result bit per cycle (floor).
// -----------------------------------------------------------------------------
module rchs_root (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [rchs_pkg::SQ_W-1:0]   x,
  output logic                        done,
  output logic [rchs_pkg::RT_W-1:0]   root
);
  import rchs_pkg::*;

  localparam int REM_W = RT_W + 2;
  localparam int CW    = $clog2(RT_W + 1);

  logic [SQ_W-1:0]  xs;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] remsh;
  logic [REM_W+1:0] trial;
  logic             ge;
  logic [CW-1:0]    cnt;
  logic             run;

  // bring down the next two radicand bits and try root*4+1
  assign remsh = {rem, xs[SQ_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root, 2'b01});
  assign ge    = remsh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        xs   <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        xs   <= {xs[SQ_W-3:0], 2'b00};
        rem  <= ge ? REM_W'(remsh - trial) : REM_W'(remsh);
        root <= {root[RT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(RT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/rchs_div.sv -----
// -----------------------------------------------------------------------------
// rchs_div
// Restoring divider giving a saturated 31-bit quotient, one bit per cycle.
// -----------------------------------------------------------------------------
module rchs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [rchs_pkg::NW-1:0]       n,
  input  logic [rchs_pkg::DW-1:0]       d,
  output logic                          done,
  output logic [rchs_pkg::DIST_W-1:0]   q
);
  import rchs_pkg::*;

  localparam int CW  = DW + DIST_W;
  localparam int CTW = $clog2(DIST_W + 1);

  logic [NW-1:0]  rem;
  logic [CW-1:0]  ds;
  logic           ge;
  logic           sat;
  logic [CTW-1:0] cnt;
  logic           run;

  // quotient does not fit: n >= d * 2^31
  assign sat = CW'(n) >= {d, {DIST_W{1'b0}}};
  assign ge  = CW'(rem) >= ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        if (sat) begin
          q    <= DIST_MAX;
          done <= 1'b1;
        end else begin
          rem <= n;
          ds  <= {1'b0, d, {(DIST_W - 1){1'b0}}};
          q   <= '0;
          cnt <= '0;
          run <= 1'b1;
        end
      end else if (run) begin
        // subtract the shifted divisor where it fits
        if (ge) begin
          rem <= rem - NW'(ds);
        end
        q   <= {q[DIST_W-2:0], ge};
        ds  <= {1'b0, ds[CW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CTW'(DIST_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ray_closest_hit_search.sv -----
// -----------------------------------------------------------------------------
// ray_closest_hit_search
// Load requests (sphere, plane) write in the accept cycle and return nothing.
// A cast strobes its result after the search of every counted sphere and then
// every counted plane, paced by the one-bit-per-cycle multiplier and the iterative
// root and divider; misses and saturated hits finish an entry sooner.
// One request at a time; busy is high from a cast until its result strobe.
// Synchronous reset clears control state and configuration registers; table memories keep contents.
// -----------------------------------------------------------------------------
module ray_closest_hit_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  rchs_pkg::req_t                   req,
  output logic                             done,
  output rchs_pkg::res_t                   result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rchs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rchs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rchs_pkg::*;

  `include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_OPS   = 4'd1;
  localparam logic [3:0] ST_MWAIT = 4'd2;
  localparam logic [3:0] ST_SEL   = 4'd3;
  localparam logic [3:0] ST_FETCH = 4'd4;
  localparam logic [3:0] ST_TEST  = 4'd5;
  localparam logic [3:0] ST_ROOT  = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_NEXT  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic [1:0] K_SPH = 2'd0;
  localparam logic [1:0] K_PLN = 2'd1;
  localparam logic [1:0] K_RAY = 2'd2;

  logic [3:0]         state;
  logic [1:0]         kind;
  logic [3:0]         op;
  logic               ph;
  logic [CNT_W-1:0]   k;

  logic [CNT_W-1:0]   sphere_count;
  logic [CNT_W-1:0]   plane_count;
  logic [COLOR_W-1:0] background_color;
  logic [CNT_W-1:0]   ns;
  logic [CNT_W-1:0]   np;

  logic signed [COORD_W-1:0] o [3];
  logic signed [COORD_W-1:0] d [3];
  logic signed [COORD_W:0]   u [3];
  op_t   a_r;
  op_t   h_r;
  op_t   c_r;
  prod_t acc;
  prod_t acc_next;

  logic               any;
  logic               bkind;
  logic [SLOT_W-1:0]  bslot;
  logic [DIST_W-1:0]  bt;
  logic [COLOR_W-1:0] bcolor;

  sphere_ent_t sph_rd;
  plane_ent_t  pln_rd;
  logic        sph_we;
  logic        pln_we;
  logic        sph_re;
  logic        pln_re;
  logic        accept;

  op_t   mx;
  op_t   my;
  logic  m_clr;
  logic  m_neg;
  logic  m_last;
  logic  mul_go;
  logic  mul_done;
  prod_t mul_p;

  logic              root_go;
  logic              root_done;
  logic [RT_W-1:0]   root_val;
  logic              div_go;
  logic              div_done;
  logic [DIST_W-1:0] div_q;
  logic [NW-1:0]     div_n;
  logic [DW-1:0]     div_d;

  logic signed [MW+1:0] nm;
  logic [MW-1:0]        abs_den;
  logic [MW-1:0]        abs_num;
  logic                 sph_miss;
  logic                 pln_miss;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // clamp counts to table sizes
  assign ns = (int'(sphere_count) < SPHERE_SLOTS) ? sphere_count : CNT_W'(SPHERE_SLOTS);
  assign np = (int'(plane_count) < PLANE_SLOTS) ? plane_count : CNT_W'(PLANE_SLOTS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count     <= '0;
      plane_count      <= '0;
      background_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPHERE_COUNT: sphere_count     <= CNT_W'(cfg_data);
        CFG_PLANE_COUNT:  plane_count      <= CNT_W'(cfg_data);
        CFG_BACKGROUND:   background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memories: loads write in the accept cycle
  assign sph_we = accept && req.mode == MODE_SPH && int'(req.slot) < SPHERE_SLOTS;
  assign pln_we = accept && req.mode == MODE_PLN && int'(req.slot) < PLANE_SLOTS;
  assign sph_re = state == ST_SEL && !ph && k < ns;
  assign pln_re = state == ST_SEL && ph && k < np;

  rchs_ram #(.WIDTH($bits(sphere_ent_t)), .DEPTH(SPHERE_SLOTS)) u_sph_ram (
    .clk   (clk),
    .we    (sph_we),
    .waddr (SPH_AW'(req.slot)),
    .wdata ({req.ax, req.ay, req.az, req.radius, req.color}),
    .re    (sph_re),
    .raddr (SPH_AW'(k)),
    .rdata (sph_rd)
  );

  rchs_ram #(.WIDTH($bits(plane_ent_t)), .DEPTH(PLANE_SLOTS)) u_pln_ram (
    .clk   (clk),
    .we    (pln_we),
    .waddr (PLN_AW'(req.slot)),
    .wdata ({req.ax, req.ay, req.az, req.bx, req.by, req.bz, req.color}),
    .re    (pln_re),
    .raddr (PLN_AW'(k)),
    .rdata (pln_rd)
  );

  // multiply-accumulate step table
  always_comb begin
    mx     = '0;
    my     = '0;
    m_clr  = 1'b0;
    m_neg  = 1'b0;
    m_last = 1'b0;
    case (kind)
      K_RAY: begin
        // a = d.d
        case (op)
          4'd0: begin mx = MW'(d[0]); my = MW'(d[0]); m_clr = 1'b1; end
          4'd1: begin mx = MW'(d[1]); my = MW'(d[1]); end
          default: begin mx = MW'(d[2]); my = MW'(d[2]); m_last = 1'b1; end
        endcase
      end
      K_SPH: begin
        // h = d.oc, c = oc.oc - r*r, disc = h*h - a*c
        case (op)
          4'd0: begin mx = MW'(d[0]); my = MW'(u[0]); m_clr = 1'b1; end
          4'd1: begin mx = MW'(d[1]); my = MW'(u[1]); end
          4'd2: begin mx = MW'(d[2]); my = MW'(u[2]); end
          4'd3: begin mx = MW'(u[0]); my = MW'(u[0]); m_clr = 1'b1; end
          4'd4: begin mx = MW'(u[1]); my = MW'(u[1]); end
          4'd5: begin mx = MW'(u[2]); my = MW'(u[2]); end
          4'd6: begin
            mx = MW'(sph_rd.radius); my = MW'(sph_rd.radius); m_neg = 1'b1;
          end
          4'd7: begin mx = h_r; my = h_r; m_clr = 1'b1; end
          default: begin mx = a_r; my = c_r; m_neg = 1'b1; m_last = 1'b1; end
        endcase
      end
      default: begin
        // den = n.d, num = (p - o).n
        case (op)
          4'd0: begin mx = MW'(pln_rd.nx); my = MW'(d[0]); m_clr = 1'b1; end
          4'd1: begin mx = MW'(pln_rd.ny); my = MW'(d[1]); end
          4'd2: begin mx = MW'(pln_rd.nz); my = MW'(d[2]); end
          4'd3: begin mx = MW'(u[0]); my = MW'(pln_rd.nx); m_clr = 1'b1; end
          4'd4: begin mx = MW'(u[1]); my = MW'(pln_rd.ny); end
          default: begin mx = MW'(u[2]); my = MW'(pln_rd.nz); m_last = 1'b1; end
        endcase
      end
    endcase
  end

  always_comb begin
    if (m_clr) begin
      acc_next = m_neg ? -mul_p : mul_p;
    end else begin
      acc_next = m_neg ? acc - mul_p : acc + mul_p;
    end
  end

  // hit tests and divider operands
  assign nm       = -(MW + 2)'(h_r) - (MW + 2)'(signed'({1'b0, root_val}));
  assign abs_den  = h_r[MW-1] ? MW'(-h_r) : MW'(h_r);
  assign abs_num  = c_r[MW-1] ? MW'(-c_r) : MW'(c_r);
  assign sph_miss = a_r == '0 || acc[PW-1];
  assign pln_miss = abs_den <= EPS_DOT || (c_r != '0 && c_r[MW-1] != h_r[MW-1]);

  assign mul_go  = state == ST_OPS;
  assign root_go = state == ST_TEST && kind == K_SPH && !sph_miss;
  assign div_go  = (state == ST_TEST && kind == K_PLN && !pln_miss) ||
                   (state == ST_ROOT && root_done && !nm[MW+1]);
  assign div_n   = (kind == K_SPH) ? {nm[MW-1:0], {FRAC_W{1'b0}}} :
                                     {abs_num, {FRAC_W{1'b0}}};
  assign div_d   = (kind == K_SPH) ? DW'(a_r) : abs_den;

  rchs_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .x    (mx),
    .y    (my),
    .done (mul_done),
    .p    (mul_p)
  );

  rchs_root u_root (
    .clk  (clk),
    .rst  (rst),
    .go   (root_go),
    .x    (acc[SQ_W-1:0]),
    .done (root_done),
    .root (root_val)
  );

  rchs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .n    (div_n),
    .d    (div_d),
    .done (div_done),
    .q    (div_q)
  );

  // cast sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      any   <= 1'b0;
      kind  <= K_RAY;
      op    <= '0;
      ph    <= 1'b0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && req.mode == MODE_CAST) begin
            o[0]   <= req.ax;
            o[1]   <= req.ay;
            o[2]   <= req.az;
            d[0]   <= req.bx;
            d[1]   <= req.by;
            d[2]   <= req.bz;
            kind   <= K_RAY;
            op     <= '0;
            ph     <= 1'b0;
            k      <= '0;
            any    <= 1'b0;
            bkind  <= 1'b0;
            bslot  <= '0;
            bt     <= '0;
            bcolor <= background_color;
            state  <= ST_OPS;
          end
        end
        ST_OPS: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            acc <= acc_next;
            // hold partial dot products
            if (op == 4'd2) begin
              if (kind == K_RAY) begin
                a_r <= MW'(acc_next);
              end else begin
                h_r <= MW'(acc_next);
              end
            end
            if ((kind == K_SPH && op == 4'd6) || (kind == K_PLN && op == 4'd5)) begin
              c_r <= MW'(acc_next);
            end
            if (m_last) begin
              state <= (kind == K_RAY) ? ST_SEL : ST_TEST;
            end else begin
              op    <= op + 1'b1;
              state <= ST_OPS;
            end
          end
        end
        ST_SEL: begin
          if (!ph) begin
            if (k < ns) begin
              state <= ST_FETCH;
            end else begin
              ph <= 1'b1;
              k  <= '0;
            end
          end else if (k < np) begin
            state <= ST_FETCH;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_FETCH: begin
          // form origin offset for the entry just read
          for (int i = 0; i < 3; i++) begin
            if (!ph) begin
              u[i] <= (COORD_W + 1)'(o[i]) -
                      (COORD_W + 1)'(i == 0 ? sph_rd.cx : (i == 1 ? sph_rd.cy : sph_rd.cz));
            end else begin
              u[i] <= (COORD_W + 1)'(i == 0 ? pln_rd.px : (i == 1 ? pln_rd.py : pln_rd.pz)) -
                      (COORD_W + 1)'(o[i]);
            end
          end
          kind  <= ph ? K_PLN : K_SPH;
          op    <= '0;
          state <= ST_OPS;
        end
        ST_TEST: begin
          if (kind == K_SPH) begin
            state <= sph_miss ? ST_NEXT : ST_ROOT;
          end else begin
            state <= pln_miss ? ST_NEXT : ST_DIV;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= nm[MW+1] ? ST_NEXT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            // keep strictly nearer hits only
            if (!any || div_q < bt) begin
              any    <= 1'b1;
              bt     <= div_q;
              bkind  <= kind == K_PLN;
              bslot  <= SLOT_W'(k);
              bcolor <= (kind == K_SPH) ? sph_rd.color : pln_rd.color;
            end
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          k     <= k + 1'b1;
          state <= ST_SEL;
        end
        ST_DONE: begin
          done               <= 1'b1;
          result.hit         <= any;
          result.kind        <= bkind;
          result.object_slot <= bslot;
          result.distance    <= bt;
          result.pixel_color <= bcolor;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `ASSERT_NEXT(a_cast_busy, clk, rst, accept && req.mode == MODE_CAST, busy, "cast not taken")
  `ASSERT_IMPL(a_div_slot, clk, rst, state == ST_DIV, (ph ? k < np : k < ns), "slot out of range")
  `ASSERT_IMPL(a_miss_zero, clk, rst, done && !result.hit,
               result.distance == '0 && result.object_slot == '0, "miss carries hit data")

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Closest-hit search testbench: loads spheres and planes, casts rays, and
// checks each hit result against an exact wide-integer prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rchs_pkg::*;

  typedef logic signed [255:0] wide_t;
  localparam wide_t EPS_W = 429496;
  localparam int U = 65536;
  localparam int CYCLE_LIMIT = 20_000_000;
  // mode code the block ignores
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ray_closest_hit_search u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // scene tables and registers as the block should hold them
  logic signed [31:0] sph_cx[16], sph_cy[16], sph_cz[16];
  logic [30:0] sph_rad[16];
  logic [23:0] sph_col[16];
  logic signed [31:0] pln_px[16], pln_py[16], pln_pz[16];
  logic signed [31:0] pln_nx[16], pln_ny[16], pln_nz[16];
  logic [23:0] pln_col[16];
  logic [4:0] sph_cnt = '0;
  logic [4:0] pln_cnt = '0;
  logic [23:0] bg_color = '0;

  req_t pending_reqs[$];
  res_t expected_hits[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 17;
  logic taken = 1'b0;

  // generator-side view of which slots hold data, for aiming and counts
  bit gen_sph_set[16];
  bit gen_pln_set[16];
  logic signed [31:0] gen_cx[16], gen_cy[16], gen_cz[16];

  function automatic wide_t isqrt_wide(wide_t x);
    wide_t r, cand;
    r = 0;
    for (int b = 68; b >= 0; b--) begin
      cand = r | (wide_t'(1) << b);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  // floor(|num| / |den|), saturated to the distance range
  function automatic logic [DIST_W-1:0] dist_quot(wide_t num, wide_t den);
    wide_t n, d, q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (n >= (d <<< 31)) return DIST_MAX;
    q = n / d;
    return q[DIST_W-1:0];
  endfunction

  function automatic res_t predict_hit(req_t r);
    wide_t ox, oy, oz, dx, dy, dz, a, h, c, disc, num, den, rr;
    int ns, np;
    logic any;
    logic [DIST_W-1:0] t;
    res_t best;
    best = '0;
    best.pixel_color = bg_color;
    any = 1'b0;
    ns = (sph_cnt > 16) ? 16 : sph_cnt;
    np = (pln_cnt > 16) ? 16 : pln_cnt;
    dx = wide_t'(r.bx);
    dy = wide_t'(r.by);
    dz = wide_t'(r.bz);
    // spheres first, smaller root only
    for (int k = 0; k < ns; k++) begin
      ox = wide_t'(r.ax) - wide_t'(sph_cx[k]);
      oy = wide_t'(r.ay) - wide_t'(sph_cy[k]);
      oz = wide_t'(r.az) - wide_t'(sph_cz[k]);
      a = dx * dx + dy * dy + dz * dz;
      if (a != 0) begin
        h = dx * ox + dy * oy + dz * oz;
        rr = wide_t'(sph_rad[k]);
        c = ox * ox + oy * oy + oz * oz - rr * rr;
        disc = h * h - a * c;
        if (disc >= 0) begin
          num = -h - isqrt_wide(disc);
          if (num >= 0) begin
            t = dist_quot(num * 65536, a);
            if (!any || t < best.distance) begin
              any = 1'b1;
              best.hit = 1'b1;
              best.kind = 1'b0;
              best.object_slot = k[3:0];
              best.distance = t;
              best.pixel_color = sph_col[k];
            end
          end
        end
      end
    end
    // then planes
    for (int k = 0; k < np; k++) begin
      den = wide_t'(pln_nx[k]) * dx + wide_t'(pln_ny[k]) * dy + wide_t'(pln_nz[k]) * dz;
      if (((den < 0) ? -den : den) > EPS_W) begin
        num = (wide_t'(pln_px[k]) - wide_t'(r.ax)) * wide_t'(pln_nx[k])
            + (wide_t'(pln_py[k]) - wide_t'(r.ay)) * wide_t'(pln_ny[k])
            + (wide_t'(pln_pz[k]) - wide_t'(r.az)) * wide_t'(pln_nz[k]);
        if (num == 0 || ((num < 0) == (den < 0))) begin
          t = dist_quot(num * 65536, den);
          if (!any || t < best.distance) begin
            any = 1'b1;
            best.hit = 1'b1;
            best.kind = 1'b1;
            best.object_slot = k[3:0];
            best.distance = t;
            best.pixel_color = pln_col[k];
          end
        end
      end
    end
    return best;
  endfunction

  // request driver: hold until taken, then move on or idle
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
      req <= pending_reqs.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results, update the scene on each taken request
  always @(posedge clk) begin
    res_t exp_r;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    taken <= start && !busy && !rst;
    if (!rst) begin
      if (done) begin
        if (expected_hits.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          exp_r = expected_hits.pop_front();
          if (result.hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, result.hit);
            errors++;
          end
          if (result.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, result.kind);
            errors++;
          end
          if (result.object_slot !== exp_r.object_slot) begin
            $error("object_slot: expected %0d, got %0d", exp_r.object_slot,
                   result.object_slot);
            errors++;
          end
          if (result.distance !== exp_r.distance) begin
            $error("distance: expected %0d, got %0d", exp_r.distance, result.distance);
            errors++;
          end
          if (result.pixel_color !== exp_r.pixel_color) begin
            $error("pixel_color: expected %h, got %h", exp_r.pixel_color,
                   result.pixel_color);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        case (req.mode)
          MODE_SPH: begin
            sph_cx[req.slot] = req.ax;
            sph_cy[req.slot] = req.ay;
            sph_cz[req.slot] = req.az;
            sph_rad[req.slot] = req.radius;
            sph_col[req.slot] = req.color;
          end
          MODE_PLN: begin
            pln_px[req.slot] = req.ax;
            pln_py[req.slot] = req.ay;
            pln_pz[req.slot] = req.az;
            pln_nx[req.slot] = req.bx;
            pln_ny[req.slot] = req.by;
            pln_nz[req.slot] = req.bz;
            pln_col[req.slot] = req.color;
          end
          MODE_CAST: expected_hits.push_back(predict_hit(req));
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SPHERE_COUNT: sph_cnt = data[4:0];
      CFG_PLANE_COUNT: pln_cnt = data[4:0];
      CFG_BACKGROUND: bg_color = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain every request and result, then let loads settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || start || expected_hits.size() > 0);
    repeat (50) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_scene(int sc, int pc, logic [23:0] bg);
    write_reg(CFG_SPHERE_COUNT, CFG_DATA_W'(sc));
    write_reg(CFG_PLANE_COUNT, CFG_DATA_W'(pc));
    write_reg(CFG_BACKGROUND, bg);
  endtask

  task automatic push_sphere(int s, int cx, int cy, int cz, logic [30:0] rad,
                             logic [23:0] col);
    req_t r;
    r = '0;
    r.mode = MODE_SPH;
    r.slot = s[3:0];
    r.ax = cx; r.ay = cy; r.az = cz;
    r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
    r.radius = rad;
    r.color = col;
    gen_sph_set[s] = 1'b1;
    gen_cx[s] = cx; gen_cy[s] = cy; gen_cz[s] = cz;
    pending_reqs.push_back(r);
  endtask

  task automatic push_plane(int s, int px, int py, int pz, int nx, int ny, int nz,
                            logic [23:0] col);
    req_t r;
    r = '0;
    r.mode = MODE_PLN;
    r.slot = s[3:0];
    r.ax = px; r.ay = py; r.az = pz;
    r.bx = nx; r.by = ny; r.bz = nz;
    r.radius = RAD_W'($urandom);
    r.color = col;
    gen_pln_set[s] = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic push_cast(int ox, int oy, int oz, int dx, int dy, int dz);
    req_t r;
    r = '0;
    r.mode = MODE_CAST;
    r.slot = SLOT_W'($urandom);
    r.ax = ox; r.ay = oy; r.az = oz;
    r.bx = dx; r.by = dy; r.bz = dz;
    r.radius = RAD_W'($urandom);
    r.color = COLOR_W'($urandom);
    pending_reqs.push_back(r);
  endtask

  function automatic int set_prefix(bit flags[16]);
    int n;
    n = 0;
    while (n < 16 && flags[n]) n++;
    return n;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return int'($urandom_range(128 * U)) - 64 * U;
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 0;
      default: return int'($urandom_range(8 * U)) - 4 * U;
    endcase
  endfunction

  // one batch of random requests under one register setting
  task automatic run_batch(int n, int max_cnt);
    int sp, pp, sc, pc, s, ox, oy, oz, k;
    sp = set_prefix(gen_sph_set);
    pp = set_prefix(gen_pln_set);
    sc = $urandom_range((sp < max_cnt) ? sp : max_cnt);
    pc = $urandom_range((pp < max_cnt) ? pp : max_cnt);
    set_scene(sc, pc, COLOR_W'($urandom));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          s = ($urandom_range(1) && sp < 16) ? sp : $urandom_range(15);
          if ($urandom_range(9) == 0)
            push_sphere(s, $urandom, $urandom, $urandom, RAD_W'($urandom),
                        COLOR_W'($urandom));
          else
            push_sphere(s, rand_coord(), rand_coord(), rand_coord(),
                        RAD_W'($urandom_range(16 * U)), COLOR_W'($urandom));
          sp = set_prefix(gen_sph_set);
        end
        5, 6, 7: begin
          s = ($urandom_range(1) && pp < 16) ? pp : $urandom_range(15);
          push_plane(s, rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                     rand_dir(), COLOR_W'($urandom));
          pp = set_prefix(gen_pln_set);
        end
        19: begin
          // mode three is ignored by the block
          pending_reqs.push_back(req_t'({MODE_IGNORED, 4'($urandom), 64'($urandom),
                                  64'($urandom), 64'($urandom), 55'($urandom)}));
        end
        default: begin
          ox = rand_coord(); oy = rand_coord(); oz = rand_coord();
          if (sc > 0 && $urandom_range(9) < 6) begin
            // aim at a sphere in use, with a little scatter
            k = $urandom_range(sc - 1);
            push_cast(ox, oy, oz,
                      ((gen_cx[k] >>> 4) - (ox >>> 4)) + int'($urandom_range(U)),
                      ((gen_cy[k] >>> 4) - (oy >>> 4)) + int'($urandom_range(U)),
                      (gen_cz[k] >>> 4) - (oz >>> 4));
          end else begin
            push_cast(ox, oy, oz, rand_dir(), rand_dir(), rand_dir());
          end
        end
      endcase
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      gen_sph_set[i] = 1'b0;
      gen_pln_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty scene, odd mode, and the tables the directed rays use
    set_scene(0, 0, 24'hFFFFFF);
    push_cast(0, 0, 0, 0, 0, U);
    pending_reqs.push_back(req_t'({MODE_IGNORED, 4'hF, {6{32'hFFFFFFFF}}, 31'h7FFFFFFF,
                                   24'hFFFFFF}));
    push_sphere(0, 0, 0, 10 * U, U, 24'h0000FF);
    push_sphere(1, 0, 0, 10 * U, U, 24'h00FF00);
    push_sphere(2, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 24'hFFFFFF);
    push_plane(0, 0, 0, 20 * U, 0, 0, -U, 24'hFF0000);
    push_plane(1, 0, 0, 0, 0, U, 0, 24'h123456);
    push_plane(2, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000, 24'h000000);
    wait_idle();

    // directed rays: tie, inside, zero direction, behind, saturation, extremes
    set_scene(3, 3, 24'h000000);
    push_cast(0, 0, 0, 0, 0, U);
    push_cast(0, 0, 10 * U, 0, 0, U);
    push_cast(0, 0, 0, 0, 0, 0);
    push_cast(0, 0, 0, 0, 0, -U);
    push_cast(0, 0, 0, 0, 0, 1);
    push_cast(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000);
    push_cast(0, -5 * U, 0, 0, U, 0);
    push_cast(0, 0, 0, U, 0, 0);
    push_cast(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF);
    wait_idle();

    // random part under three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 48 : 0;
      for (int b = 0; b < 7; b++) run_batch(27, 3);
    end

    // fill both tables, then search them whole
    for (int s = 0; s < 16; s++) begin
      push_sphere(s, rand_coord(), rand_coord(), rand_coord(),
                  RAD_W'($urandom_range(16 * U)), COLOR_W'($urandom));
      push_plane(s, rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                 rand_dir(), COLOR_W'($urandom));
    end
    wait_idle();
    set_scene(16, 16, 24'hFFFFFF);
    push_cast(0, 0, 0, gen_cx[5] >>> 4, gen_cy[5] >>> 4, gen_cz[5] >>> 4);
    push_cast(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
    wait_idle();
    write_reg(CFG_SPHERE_COUNT, {19'($urandom), 5'd31});
    write_reg(CFG_PLANE_COUNT, {19'($urandom), 5'd31});
    write_reg(CFG_BACKGROUND, 24'h000000);
    push_cast(0, 0, 0, gen_cx[9] >>> 4, gen_cy[9] >>> 4, gen_cz[9] >>> 4);
    push_cast(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
    wait_idle();

    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rchs_pkg.sv
rtl/rchs_ram.sv
rtl/rchs_mul.sv
rtl/rchs_root.sv
rtl/rchs_div.sv
rtl/ray_closest_hit_search.sv
sim/tb_top.sv
